// ===== design/next_fit_zone_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// next fit zone allocator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_ZONE_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_ZONE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define NFZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NFZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/nfz_pkg.sv =====
// ----------------------------------------------------------------------------
// nfz_pkg
// types, codes and helpers of the next fit zone allocator
// ----------------------------------------------------------------------------
package nfz_pkg;

  localparam int WORK_W     = 20;
  localparam int NEED_W     = 14;
  localparam int TAG_W      = 8;
  localparam int SPLIT_MIN  = 8;
  localparam int GUARD_B    = 4;
  localparam int ZONE_RST_B = 49152;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_SPACE     = 3'd1;
  localparam logic [2:0] ST_ZERO_TAG     = 3'd2;
  localparam logic [2:0] ST_NOT_BLOCK    = 3'd3;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

  localparam logic       REG_ZONE_USABLE = 1'b0;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_bytes;
    logic [7:0]  owner_tag;
    logic [15:0] user_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload_offset;
    logic [16:0] block_bytes;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_EVAL, S_A_WB, S_A_WS, S_A_RX, S_A_WX,
    S_F_CB, S_F_CP, S_F_CN, S_F_W0, S_F_W1, S_F_W2, S_F_X, S_F_WX, S_OUT
  } nfz_state_t;

  // usable granules from the byte register, clamped to [8, zg]
  function automatic logic [WORK_W-1:0] ugran_of(input logic [16:0] b,
                                                 input logic [WORK_W-1:0] zg);
    logic [WORK_W-1:0] g;
    g = WORK_W'(b[16:3]);
    if (b < 17'd64) begin
      ugran_of = WORK_W'(8);
    end else if (g > zg) begin
      ugran_of = zg;
    end else begin
      ugran_of = g;
    end
  endfunction

endpackage

// ===== design/next_fit_zone_allocator.sv =====
// Allocate: a next-fit scan from the rover reads one header per block, then writes the
// new header and, on a split, the remainder and its successor's prev link. Free: header
// reads of the block and both neighbors, then merge writes. One word at a time; the
// single-port header table paces both operations. After reset and each zone_usable_bytes
// write, clearing all ZONE_GRANULES entries rebuilds the table; in_ready is low meanwhile.
// ----------------------------------------------------------------------------
// next_fit_zone_allocator
// next fit allocator over 8-byte granules with coalescing on free
// ----------------------------------------------------------------------------
module next_fit_zone_allocator #(
  parameter int ZONE_GRANULES = 8192,
  parameter int HEADER_BYTES  = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nfz_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nfz_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import nfz_pkg::*;

  localparam int AW = $clog2(ZONE_GRANULES);
  localparam int GW = $clog2(ZONE_GRANULES + 1);
  localparam int DW = 2 * GW + TAG_W + 1;

  // header word: mark, size, tag, prev
  localparam int SZ_LO = GW + TAG_W;
  localparam int TG_LO = GW;

  logic          zone_wr;
  logic [GW-1:0] ugran;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata, rd_word;

  nfz_state_t    state_r, state_nxt;
  logic [GW-1:0] rover_r, rover_nxt, tail_r, tail_nxt;
  logic [GW-1:0] base_r, base_nxt, rov_r, rov_nxt, start_r, start_nxt;
  logic [GW+1:0] iter_r, iter_nxt;
  logic          ld_r, ld_nxt, chk_r, chk_nxt, first_r, first_nxt;
  logic          bt_r, bt_nxt;
  logic [GW-1:0] bs_r, bs_nxt, bp_r, bp_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [GW-1:0] p_r, p_nxt, psz_r, psz_nxt, pprv_r, pprv_nxt;
  logic          pfree_r, pfree_nxt, nfree_r, nfree_nxt;
  logic [GW-1:0] nb_r, nb_nxt, nsz_r, nsz_nxt, m_r, m_nxt, msz_r, msz_nxt, mprv_r, mprv_nxt;
  logic [DW-1:0] nword_r, nword_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          rd_virt_r, rd_virt_nxt;
  logic [GW-1:0] rd_idx_r, rd_idx_nxt;
  out_item_t     res_r, res_nxt, out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic             cur_mark, cur_tag;
  logic [GW-1:0]    cur_size, cur_prev, cur_next;
  logic             e_bt;
  logic [GW-1:0]    e_bs, e_bp, e_start;
  logic             fit;
  logic [GW-1:0]    extra, new_sz, nm, nx;
  logic [WORK_W-1:0] need_w, off_w, sub_w, blk_w, pay_w, abytes_w, fbytes_w, msum_w;

  nfz_apb #(.ZONE_GRANULES(ZONE_GRANULES)) u_apb (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .zone_wr(zone_wr), .ugran(ugran)
  );

  nfz_hdr_ram #(.DEPTH(ZONE_GRANULES), .DW(DW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rd_word)
  );

  // header view of the last read, sentinel answers as used and empty
  assign cur_mark = rd_virt_r ? 1'b0 : rd_word[DW-1];
  assign cur_tag  = rd_virt_r ? 1'b1 : (rd_word[TG_LO +: TAG_W] != '0);
  assign cur_size = rd_virt_r ? '0 : rd_word[SZ_LO +: GW];
  assign cur_prev = rd_virt_r ? tail_r : rd_word[GW-1:0];
  assign cur_next = rd_virt_r ? '0 : GW'(rd_idx_r + cur_size);

  assign e_bt    = ld_r ? cur_tag : bt_r;
  assign e_bs    = ld_r ? cur_size : bs_r;
  assign e_bp    = ld_r ? cur_prev : bp_r;
  assign e_start = first_r ? cur_prev : start_r;
  assign fit     = !e_bt && (WORK_W'(e_bs) >= WORK_W'(need_r));

  assign extra  = GW'(bs_r - GW'(need_r));
  assign new_sz = (WORK_W'(extra) > WORK_W'(SPLIT_MIN)) ? GW'(need_r) : bs_r;
  assign nm     = GW'(base_r + GW'(need_r));
  assign nx     = GW'(base_r + bs_r);

  assign need_w   = (WORK_W'(in_data.request_bytes)
                    + WORK_W'(HEADER_BYTES + GUARD_B + 7)) >> 3;
  assign off_w    = WORK_W'(in_data.user_offset);
  assign sub_w    = off_w - WORK_W'(HEADER_BYTES);
  assign blk_w    = sub_w >> 3;
  assign pay_w    = (WORK_W'(base_r) << 3) + WORK_W'(HEADER_BYTES);
  assign abytes_w = WORK_W'(new_sz) << 3;
  assign fbytes_w = WORK_W'(msz_r) << 3;
  assign msum_w   = WORK_W'(pfree_r ? psz_r : '0) + WORK_W'(bs_r)
                  + WORK_W'(!cur_tag ? cur_size : '0);

  always_comb begin
    state_nxt   = state_r;
    rover_nxt   = rover_r;
    tail_nxt    = tail_r;
    base_nxt    = base_r;
    rov_nxt     = rov_r;
    start_nxt   = start_r;
    iter_nxt    = iter_r;
    ld_nxt      = ld_r;
    chk_nxt     = chk_r;
    first_nxt   = first_r;
    bt_nxt      = bt_r;
    bs_nxt      = bs_r;
    bp_nxt      = bp_r;
    need_nxt    = need_r;
    tag_nxt     = tag_r;
    p_nxt       = p_r;
    psz_nxt     = psz_r;
    pprv_nxt    = pprv_r;
    pfree_nxt   = pfree_r;
    nfree_nxt   = nfree_r;
    nb_nxt      = nb_r;
    nsz_nxt     = nsz_r;
    m_nxt       = m_r;
    msz_nxt     = msz_r;
    mprv_nxt    = mprv_r;
    nword_nxt   = nword_r;
    clr_cnt_nxt = clr_cnt_r;
    rd_virt_nxt = rd_virt_r;
    rd_idx_nxt  = rd_idx_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;
    in_ready    = 1'b0;

    case (state_r)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
        if (clr_cnt_r == '0) begin
          ram_wdata = {1'b1, ugran, {TAG_W{1'b0}}, ugran};
        end
        clr_cnt_nxt = AW'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == AW'(ZONE_GRANULES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        res_nxt  = '0;
        if (in_valid) begin
          if (in_data.opcode == OP_ALLOC) begin
            if (in_data.owner_tag == '0) begin
              res_nxt.status = ST_ZERO_TAG;
              state_nxt      = S_OUT;
            end else begin
              need_nxt    = in_data.owner_tag != '0 ? need_w[NEED_W-1:0] : need_r;
              tag_nxt     = in_data.owner_tag;
              base_nxt    = rover_r;
              rov_nxt     = rover_r;
              iter_nxt    = '0;
              ld_nxt      = 1'b1;
              chk_nxt     = 1'b0;
              first_nxt   = 1'b1;
              ram_addr    = rover_r[AW-1:0];
              rd_idx_nxt  = rover_r;
              rd_virt_nxt = (rover_r >= ugran);
              state_nxt   = S_A_EVAL;
            end
          end else begin
            if ((off_w < WORK_W'(HEADER_BYTES)) || (sub_w[2:0] != 3'd0)
                || (blk_w >= WORK_W'(ugran))) begin
              res_nxt.status = ST_NOT_BLOCK;
              state_nxt      = S_OUT;
            end else begin
              base_nxt    = blk_w[GW-1:0];
              ram_addr    = blk_w[AW-1:0];
              rd_idx_nxt  = blk_w[GW-1:0];
              rd_virt_nxt = 1'b0;
              state_nxt   = S_F_CB;
            end
          end
        end
      end
      S_A_EVAL: begin
        bt_nxt    = e_bt;
        bs_nxt    = e_bs;
        bp_nxt    = e_bp;
        start_nxt = e_start;
        first_nxt = 1'b0;
        if (chk_r && fit) begin
          state_nxt = S_A_WB;
        end else if ((rov_r == e_start)
                     || (WORK_W'(iter_r) > WORK_W'(ugran) + WORK_W'(2))) begin
          res_nxt.status = ST_NO_SPACE;
          state_nxt      = S_OUT;
        end else begin
          iter_nxt = (GW+2)'(iter_r + 1'b1);
          rov_nxt  = cur_next;
          if (cur_tag) begin
            base_nxt    = cur_next;
            ld_nxt      = 1'b1;
            chk_nxt     = 1'b1;
            ram_addr    = cur_next[AW-1:0];
            rd_idx_nxt  = cur_next;
            rd_virt_nxt = (cur_next >= ugran);
          end else if (fit) begin
            state_nxt = S_A_WB;
          end else begin
            ld_nxt      = 1'b0;
            chk_nxt     = 1'b0;
            ram_addr    = cur_next[AW-1:0];
            rd_idx_nxt  = cur_next;
            rd_virt_nxt = (cur_next >= ugran);
          end
        end
      end
      S_A_WB: begin
        ram_we    = 1'b1;
        ram_addr  = base_r[AW-1:0];
        ram_wdata = {1'b1, new_sz, tag_r, bp_r};
        rover_nxt = GW'(base_r + new_sz);
        res_nxt.status         = ST_OK;
        res_nxt.payload_offset = pay_w[15:0];
        res_nxt.block_bytes    = abytes_w[16:0];
        state_nxt = (new_sz != bs_r) ? S_A_WS : S_OUT;
      end
      S_A_WS: begin
        ram_we    = 1'b1;
        ram_addr  = nm[AW-1:0];
        ram_wdata = {1'b1, extra, {TAG_W{1'b0}}, base_r};
        if (nx >= ugran) begin
          tail_nxt  = nm;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_A_RX;
        end
      end
      S_A_RX: begin
        ram_addr  = nx[AW-1:0];
        state_nxt = S_A_WX;
      end
      S_A_WX: begin
        ram_we    = 1'b1;
        ram_addr  = nx[AW-1:0];
        ram_wdata = {rd_word[DW-1:GW], nm};
        state_nxt = S_OUT;
      end
      S_F_CB: begin
        if (!cur_mark) begin
          res_nxt.status = ST_NOT_BLOCK;
          state_nxt      = S_OUT;
        end else if (!cur_tag) begin
          res_nxt.status = ST_ALREADY_FREE;
          state_nxt      = S_OUT;
        end else begin
          bs_nxt      = cur_size;
          bp_nxt      = cur_prev;
          p_nxt       = cur_prev;
          ram_addr    = cur_prev[AW-1:0];
          rd_idx_nxt  = cur_prev;
          rd_virt_nxt = (cur_prev >= ugran);
          state_nxt   = S_F_CP;
        end
      end
      S_F_CP: begin
        pfree_nxt   = !cur_tag;
        psz_nxt     = cur_size;
        pprv_nxt    = cur_prev;
        nb_nxt      = GW'(base_r + bs_r);
        ram_addr    = nb_nxt[AW-1:0];
        rd_idx_nxt  = nb_nxt;
        rd_virt_nxt = (nb_nxt >= ugran);
        state_nxt   = S_F_CN;
      end
      S_F_CN: begin
        nfree_nxt = !cur_tag;
        nsz_nxt   = cur_size;
        nword_nxt = rd_word;
        m_nxt     = pfree_r ? p_r : base_r;
        mprv_nxt  = pfree_r ? pprv_r : bp_r;
        msz_nxt   = msum_w[GW-1:0];
        if (pfree_r && (rover_r == base_r)) begin
          rover_nxt = p_r;
        end
        if (!cur_tag && (rover_r == nb_r)) begin
          rover_nxt = pfree_r ? p_r : base_r;
        end
        state_nxt = S_F_W0;
      end
      S_F_W0: begin
        ram_we    = 1'b1;
        ram_addr  = m_r[AW-1:0];
        ram_wdata = {1'b1, msz_r, {TAG_W{1'b0}}, mprv_r};
        res_nxt.status      = ST_OK;
        res_nxt.block_bytes = fbytes_w[16:0];
        state_nxt = S_F_W1;
      end
      S_F_W1: begin
        ram_we    = pfree_r;
        ram_addr  = base_r[AW-1:0];
        state_nxt = S_F_W2;
      end
      S_F_W2: begin
        ram_addr = nb_r[AW-1:0];
        if (nfree_r) begin
          ram_we    = 1'b1;
          state_nxt = S_F_X;
        end else if (nb_r >= ugran) begin
          tail_nxt  = m_r;
          state_nxt = S_OUT;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {nword_r[DW-1:GW], m_r};
          state_nxt = S_OUT;
        end
      end
      S_F_X: begin
        nb_nxt   = GW'(nb_r + nsz_r);
        ram_addr = nb_nxt[AW-1:0];
        if (nb_nxt >= ugran) begin
          tail_nxt  = m_r;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_F_WX;
        end
      end
      S_F_WX: begin
        ram_we    = 1'b1;
        ram_addr  = nb_r[AW-1:0];
        ram_wdata = {rd_word[DW-1:GW], m_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // zone rebuild on register write
    if (zone_wr) begin
      state_nxt   = S_CLR;
      clr_cnt_nxt = '0;
      rover_nxt   = '0;
      tail_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      rover_r     <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rover_r     <= rover_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    rov_r     <= rov_nxt;
    start_r   <= start_nxt;
    iter_r    <= iter_nxt;
    ld_r      <= ld_nxt;
    chk_r     <= chk_nxt;
    first_r   <= first_nxt;
    bt_r      <= bt_nxt;
    bs_r      <= bs_nxt;
    bp_r      <= bp_nxt;
    need_r    <= need_nxt;
    tag_r     <= tag_nxt;
    p_r       <= p_nxt;
    psz_r     <= psz_nxt;
    pprv_r    <= pprv_nxt;
    pfree_r   <= pfree_nxt;
    nfree_r   <= nfree_nxt;
    nb_r      <= nb_nxt;
    nsz_r     <= nsz_nxt;
    m_r       <= m_nxt;
    msz_r     <= msz_nxt;
    mprv_r    <= mprv_nxt;
    nword_r   <= nword_nxt;
    rd_virt_r <= rd_virt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/nfz_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// nfz_hdr_ram
// single port header table, registered read
// ----------------------------------------------------------------------------
module nfz_hdr_ram #(
  parameter int DEPTH = 8192,
  parameter int DW    = 37
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DW-1:0]            wdata,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/nfz_apb.sv =====
// ----------------------------------------------------------------------------
// nfz_apb
// zone size register and zone reset request
// ----------------------------------------------------------------------------
module nfz_apb #(
  parameter int ZONE_GRANULES = 8192
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  output logic                                  zone_wr,
  output logic [$clog2(ZONE_GRANULES+1)-1:0]    ugran
);
  import nfz_pkg::*;

  localparam int GW = $clog2(ZONE_GRANULES + 1);
  localparam logic [WORK_W-1:0] ZG = WORK_W'(ZONE_GRANULES);

  logic [16:0]   zone_bytes_r, zone_bytes_nxt;
  logic [GW-1:0] ugran_r, ugran_nxt;
  logic [WORK_W-1:0] ug_w, ug_rst;
  logic          wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ZONE_USABLE);
  assign ug_w   = ugran_of(pwdata[16:0], ZG);
  assign ug_rst = ugran_of(17'(ZONE_RST_B), ZG);

  always_comb begin
    zone_bytes_nxt = zone_bytes_r;
    ugran_nxt      = ugran_r;
    if (wr_hit) begin
      zone_bytes_nxt = pwdata[16:0];
      ugran_nxt      = ug_w[GW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_bytes_r <= 17'(ZONE_RST_B);
      ugran_r      <= ug_rst[GW-1:0];
    end else begin
      zone_bytes_r <= zone_bytes_nxt;
      ugran_r      <= ugran_nxt;
    end
  end

  assign prdata  = (paddr[2] == REG_ZONE_USABLE) ? {15'd0, zone_bytes_r} : 32'd0;
  assign zone_wr = wr_hit;
  assign ugran   = ugran_r;

endmodule

// ===== design/nfz_checker.sv =====
// ----------------------------------------------------------------------------
// nfz_checker
// port level checks of the next fit zone allocator
// ----------------------------------------------------------------------------
`include "next_fit_zone_allocator_macros.svh"

module nfz_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input nfz_pkg::out_item_t out_data
);
  import nfz_pkg::*;

  `NFZ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped while stalled")
  `NFZ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word taken while busy")
  `NFZ_ASSERT_NOW(a_err_zero, out_valid && (out_data.status != ST_OK), (out_data.payload_offset == 16'd0) && (out_data.block_bytes == 17'd0), "error result carries data")
  `NFZ_ASSERT_NOW(a_gran_bytes, out_valid, out_data.block_bytes[2:0] == 3'd0, "block size not granule aligned")
  `NFZ_ASSERT_NOW(a_status_code, out_valid, (out_data.status == ST_OK) || (out_data.status == ST_NO_SPACE) || (out_data.status == ST_ZERO_TAG) || (out_data.status == ST_NOT_BLOCK) || (out_data.status == ST_ALREADY_FREE), "unknown status")

endmodule

bind next_fit_zone_allocator nfz_checker u_nfz_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// next fit zone allocator testbench
// drives allocate and free words against a software copy of the zone headers,
// checks every result word in order, writes the zone size register between
// phases and runs idle, stall and long back-pressure phases
// ----------------------------------------------------------------------------
module testbench;
  import nfz_pkg::*;

  localparam int ZG  = 8192;
  localparam int HDR = 24;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  next_fit_zone_allocator #(.ZONE_GRANULES(ZG), .HEADER_BYTES(HDR)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // zone header copy
  int        hdr_mark [ZG];
  int        hdr_size [ZG];
  int        hdr_tag  [ZG];
  int        hdr_prev [ZG];
  int        rover;
  int        tail_prev;
  int        ugran;
  int        live_offsets[$];
  out_item_t expected_words[$];

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int hold_seen = 0;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  initial begin
    #4000000;
    $display("next_fit_zone_allocator verification failed");
    $finish;
  end

  function automatic int tag_of(int i);
    return i >= ugran ? 1 : hdr_tag[i];
  endfunction

  function automatic int size_of(int i);
    return i >= ugran ? 0 : hdr_size[i];
  endfunction

  function automatic int next_of(int i);
    return i >= ugran ? 0 : i + hdr_size[i];
  endfunction

  function automatic int prev_of(int i);
    return i >= ugran ? tail_prev : hdr_prev[i];
  endfunction

  function automatic void link_prev(int i, int p);
    if (i >= ugran) tail_prev = p;
    else hdr_prev[i] = p;
  endfunction

  function automatic void zone_clear(int reg_val);
    int b;
    b = reg_val & 32'h1FFFF;
    if (b < 64) b = 64;
    if (b > ZG * 8) b = ZG * 8;
    ugran = b >> 3;
    for (int i = 0; i < ZG; i++) begin
      hdr_mark[i] = 0; hdr_size[i] = 0; hdr_tag[i] = 0; hdr_prev[i] = 0;
    end
    hdr_mark[0] = 1;
    hdr_size[0] = ugran;
    hdr_prev[0] = ugran;
    tail_prev = 0;
    rover = 0;
    live_offsets.delete();
  endfunction

  function automatic out_item_t zone_alloc(int req, int tag);
    out_item_t r;
    int need, base, rov, start, iter, extra, nm, nx;
    r = '0;
    if (tag == 0) begin
      r.status = ST_ZERO_TAG;
      return r;
    end
    need = (req + HDR + GUARD_B + 7) >> 3;
    base = rover;
    rov = rover;
    start = prev_of(base);
    iter = 0;
    while (1) begin
      if (rov == start || iter > ugran + 2) begin
        r.status = ST_NO_SPACE;
        return r;
      end
      if (tag_of(rov) != 0) begin
        rov = next_of(rov);
        base = rov;
      end else begin
        rov = next_of(rov);
      end
      if (!(tag_of(base) != 0 || size_of(base) < need)) break;
      iter++;
    end
    extra = hdr_size[base] - need;
    if (extra > SPLIT_MIN) begin
      nm = base + need;
      nx = base + hdr_size[base];
      hdr_mark[nm] = 1;
      hdr_size[nm] = extra;
      hdr_tag[nm] = 0;
      hdr_prev[nm] = base;
      link_prev(nx, nm);
      hdr_size[base] = need;
    end
    hdr_tag[base] = tag;
    hdr_mark[base] = 1;
    rover = base + hdr_size[base];
    r.status = ST_OK;
    r.payload_offset = 16'(base * 8 + HDR);
    r.block_bytes = 17'(hdr_size[base] * 8);
    live_offsets.push_back(base * 8 + HDR);
    return r;
  endfunction

  function automatic out_item_t zone_free(int off);
    out_item_t r;
    int blk, oth, idx[$];
    r = '0;
    if (off < HDR || ((off - HDR) & 7) != 0) begin
      r.status = ST_NOT_BLOCK;
      return r;
    end
    blk = (off - HDR) >> 3;
    if (blk >= ugran || hdr_mark[blk] == 0) begin
      r.status = ST_NOT_BLOCK;
      return r;
    end
    if (hdr_tag[blk] == 0) begin
      r.status = ST_ALREADY_FREE;
      return r;
    end
    idx = live_offsets.find_first_index(x) with (x == off);
    if (idx.size() != 0) live_offsets.delete(idx[0]);
    hdr_tag[blk] = 0;
    oth = prev_of(blk);
    if (tag_of(oth) == 0) begin
      hdr_size[oth] += hdr_size[blk];
      link_prev(next_of(oth), oth);
      hdr_mark[blk] = 0;
      if (rover == blk) rover = oth;
      blk = oth;
    end
    oth = next_of(blk);
    if (tag_of(oth) == 0) begin
      hdr_size[blk] += hdr_size[oth];
      hdr_mark[oth] = 0;
      link_prev(next_of(blk), blk);
      if (rover == oth) rover = blk;
    end
    r.status = ST_OK;
    r.block_bytes = 17'(hdr_size[blk] * 8);
    return r;
  endfunction

  // sender: caller is just past a rising edge
  task automatic send_word(input in_item_t w);
    int gap;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (w.opcode == OP_ALLOC)
      expected_words.push_back(zone_alloc(int'(w.request_bytes), int'(w.owner_tag)));
    else
      expected_words.push_back(zone_free(int'(w.user_offset)));
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_alloc(input int req, input int tag);
    in_item_t w;
    w = '0;
    w.opcode = OP_ALLOC;
    w.request_bytes = 16'(req);
    w.owner_tag = 8'(tag);
    w.user_offset = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_free(input int off);
    in_item_t w;
    w = '0;
    w.opcode = OP_FREE;
    w.request_bytes = 16'($urandom);
    w.owner_tag = 8'($urandom);
    w.user_offset = 16'(off);
    send_word(w);
  endtask

  task automatic drain;
    if (in_valid) in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_zone_size(input int v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_ZONE_USABLE);
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    zone_clear(v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic free_live;
    int k;
    k = $urandom_range(live_offsets.size() - 1);
    send_free(live_offsets[k]);
  endtask

  task automatic random_word;
    int p;
    p = $urandom_range(99);
    if (p < 50 || live_offsets.size() == 0) begin
      if ($urandom_range(9) < 8) send_alloc($urandom_range(0, 120), $urandom_range(1, 255));
      else send_alloc($urandom_range(0, 700), $urandom_range(1, 255));
    end else if (p < 88) begin
      free_live();
    end else if (p < 92) begin
      send_alloc($urandom, $urandom);
    end else if (p < 96) begin
      send_free($urandom);
    end else begin
      send_free(live_offsets[$urandom_range(live_offsets.size() - 1)] + $urandom_range(1, 8));
    end
  endtask

  task automatic test_reset_zone;
    int a;
    send_alloc(100, 7);
    a = live_offsets[0];
    send_alloc(0, 1);
    send_free(a);
    send_free(a);
  endtask

  task automatic test_directed;
    int a, b, c;
    write_zone_size(512);
    send_alloc(10, 0);
    send_alloc(65535, 1);
    send_alloc(0, 255);
    send_alloc(100, 128);
    send_alloc(40, 3);
    a = live_offsets[0]; b = live_offsets[1]; c = live_offsets[2];
    send_free(0);
    send_free(HDR + 1);
    send_free(16'hFFFF);
    send_free(a + 8);
    send_free(b);
    send_free(b);
    send_free(a);
    send_free(b);
    send_free(c);
    send_alloc(400, 9);
    send_alloc(10, 9);
  endtask

  task automatic test_min_zone;
    int a;
    write_zone_size(0);
    send_alloc(36, 5);
    a = live_offsets[0];
    send_alloc(0, 5);
    send_free(a);
    send_alloc(36, 6);
    send_alloc(37, 6);
  endtask

  task automatic test_max_zone;
    write_zone_size(17'h1FFFF);
    send_alloc(65535, 1);
    send_alloc(65000, 2);
    send_alloc(0, 3);
    free_live();
    send_alloc(30000, 4);
    repeat (6) random_word();
  endtask

  task automatic test_random(input int zone, input int idl, input int stl, input int n);
    write_zone_size(zone);
    idle_pct = idl;
    stall_pct = stl;
    repeat (n) random_word();
  endtask

  task automatic test_backpressure;
    write_zone_size(4096);
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles <= hold_cycles + 600;
    repeat (30) send_alloc($urandom_range(0, 60), $urandom_range(1, 255));
    repeat (10) free_live();
  endtask

  always @(posedge clk) begin
    if (hold_seen < hold_cycles) begin
      out_ready <= 1'b0;
      hold_seen <= hold_seen + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word %h", $time, out_data);
        errors++;
      end else begin
        out_item_t e;
        e = expected_words.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t status exp %0d got %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.payload_offset !== e.payload_offset) begin
          $display("%0t payload_offset exp %0d got %0d", $time, e.payload_offset,
                   out_data.payload_offset);
          errors++;
        end
        if (out_data.block_bytes !== e.block_bytes) begin
          $display("%0t block_bytes exp %0d got %0d", $time, e.block_bytes,
                   out_data.block_bytes);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    zone_clear(ZONE_RST_B);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_zone();
    test_directed();
    test_min_zone();
    test_max_zone();
    test_random(2048, 0, 0, 200);
    test_random(1003, 58, 0, 200);
    test_random(4096, 0, 58, 200);
    test_random(3000, 19, 19, 200);
    test_backpressure();
    test_random(ZONE_RST_B, 0, 0, 60);
    drain();
    if (errors == 0) begin
      $display("next_fit_zone_allocator verification clean");
    end else begin
      $display("next_fit_zone_allocator verification failed");
    end
    $finish;
  end

endmodule
